// ===== design/lifo_hr_pkg.sv =====
`default_nettype none

package lifo_hr_pkg;

  localparam int DEFAULT_STACK_DEPTH = 256;

  localparam int CMD_W    = 2;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 2;
  localparam int FILL_W   = 9;

  localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SWAP = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // Word returned by a pop on an empty stack.
  localparam logic signed [WORD_W-1:0] EMPTY_POP_VALUE = -32'sd1;

endpackage

`default_nettype wire

// ===== design/lifo_stack_with_half_rotate.sv =====
`default_nettype none

// Channel  Direction  Handshake            Payload
// in_      input      in_valid/in_stall    in_cmd, in_push_value
// out_     output     out_valid/out_stall  out_pop_value, out_status, out_fill_count
//
// A push, or a pop or swap-halves on an empty stack, goes straight to the result state;
// a pop first reads the top entry. Each result then waits until the output register is free.
// Swap-halves on n entries reverses three ranges (the lower k = n - n/2 entries, the upper
// n - k, then all n), one entry pair at a time: a read, then two writes.
// Synchronous reset empties the stack and leaves memory contents as they are.
// in_stall is high from the cycle after a request is taken until its result is loaded.

module lifo_stack_with_half_rotate #(
  parameter int STACK_DEPTH = lifo_hr_pkg::DEFAULT_STACK_DEPTH
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic [lifo_hr_pkg::CMD_W-1:0]          in_cmd,
  input  wire logic signed [lifo_hr_pkg::WORD_W-1:0]  in_push_value,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic signed [lifo_hr_pkg::WORD_W-1:0]       out_pop_value,
  output logic [lifo_hr_pkg::STATUS_W-1:0]            out_status,
  output logic [lifo_hr_pkg::FILL_W-1:0]              out_fill_count
);

  import lifo_hr_pkg::*;

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_SW_CHK,
    S_SW_WA,
    S_SW_WB,
    S_FIN
  } state_t;

  typedef enum logic [1:0] {
    PH_LOW,
    PH_HIGH,
    PH_ALL
  } phase_t;

  state_t                    state_r, state_nxt;
  phase_t                    phase_r, phase_nxt;
  logic [CW-1:0]             count_r, count_nxt;
  logic [CW-1:0]             half_k_r, half_k_nxt;
  logic [CW-1:0]             lo_r, lo_nxt;
  logic [CW-1:0]             hi_r, hi_nxt;
  logic signed [WORD_W-1:0]  res_value_r, res_value_nxt;
  logic [STATUS_W-1:0]       res_status_r, res_status_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic signed [WORD_W-1:0]  out_value_r, out_value_nxt;
  logic [STATUS_W-1:0]       out_status_r, out_status_nxt;
  logic [FILL_W-1:0]         out_fill_r, out_fill_nxt;

  logic signed [WORD_W-1:0]  mem [STACK_DEPTH];
  logic signed [WORD_W-1:0]  rd_a_r, rd_b_r;
  logic                      wr_en, rd_en;
  logic [AW-1:0]             wr_addr, rd_a_addr, rd_b_addr;
  logic signed [WORD_W-1:0]  wr_data;

  logic [CW-1:0]             cnt_dec;
  logic [CW-1:0]             keep_k;

  assign cnt_dec = count_r - CW'(1);
  // Entries that end up on top after swap-halves.
  assign keep_k  = count_r - (count_r >> 1);

  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    count_nxt      = count_r;
    half_k_nxt     = half_k_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    res_value_nxt  = res_value_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_fill_nxt   = out_fill_r;
    wr_en          = 1'b0;
    wr_addr        = lo_r[AW-1:0];
    wr_data        = rd_b_r;
    rd_en          = 1'b0;
    rd_a_addr      = lo_r[AW-1:0];
    rd_b_addr      = hi_r[AW-1:0];

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          res_value_nxt  = '0;
          res_status_nxt = ST_OK;
          state_nxt      = S_FIN;
          unique case (in_cmd)
            CMD_PUSH: begin
              if (count_r >= CW'(STACK_DEPTH)) begin
                res_status_nxt = ST_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = count_r[AW-1:0];
                wr_data   = in_push_value;
                count_nxt = count_r + CW'(1);
              end
            end
            CMD_POP: begin
              if (count_r == '0) begin
                res_value_nxt  = EMPTY_POP_VALUE;
                res_status_nxt = ST_EMPTY;
              end else begin
                rd_en     = 1'b1;
                rd_a_addr = cnt_dec[AW-1:0];
                count_nxt = cnt_dec;
                state_nxt = S_POP;
              end
            end
            CMD_SWAP: begin
              if (count_r == '0) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                half_k_nxt = keep_k;
                phase_nxt  = PH_LOW;
                lo_nxt     = '0;
                hi_nxt     = keep_k - CW'(1);
                state_nxt  = S_SW_CHK;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_POP: begin
        res_value_nxt = rd_a_r;
        state_nxt     = S_FIN;
      end
      S_SW_CHK: begin
        // Rotation is done as three in-place reversals of stack ranges.
        if (lo_r < hi_r) begin
          rd_en     = 1'b1;
          state_nxt = S_SW_WA;
        end else begin
          unique case (phase_r)
            PH_LOW: begin
              phase_nxt = PH_HIGH;
              lo_nxt    = half_k_r;
              hi_nxt    = cnt_dec;
            end
            PH_HIGH: begin
              phase_nxt = PH_ALL;
              lo_nxt    = '0;
              hi_nxt    = cnt_dec;
            end
            default: begin
              state_nxt = S_FIN;
            end
          endcase
        end
      end
      S_SW_WA: begin
        wr_en     = 1'b1;
        wr_addr   = lo_r[AW-1:0];
        wr_data   = rd_b_r;
        state_nxt = S_SW_WB;
      end
      S_SW_WB: begin
        wr_en     = 1'b1;
        wr_addr   = hi_r[AW-1:0];
        wr_data   = rd_a_r;
        lo_nxt    = lo_r + CW'(1);
        hi_nxt    = hi_r - CW'(1);
        state_nxt = S_SW_CHK;
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = res_value_r;
          out_status_nxt = res_status_r;
          out_fill_nxt   = FILL_W'(count_r);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_LOW;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    half_k_r     <= half_k_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    res_value_r  <= res_value_nxt;
    res_status_r <= res_status_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_fill_r   <= out_fill_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data must hold across both writes of a swap pair.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a_r <= mem[rd_a_addr];
      rd_b_r <= mem[rd_b_addr];
    end
  end

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_pop_value  = out_value_r;
  assign out_status     = out_status_r;
  assign out_fill_count = out_fill_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(STACK_DEPTH))
    else $error("stack count exceeds depth");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |-> (out_fill_count == FILL_W'(STACK_DEPTH)))
    else $error("full status with stack not full");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_EMPTY) |-> (out_fill_count == '0))
    else $error("empty status with entries held");

  a_swap_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SW_WA || state_r == S_SW_WB) |=> $stable(count_r))
    else $error("count changed during swap");

  a_swap_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SW_WA) |-> (lo_r < hi_r))
    else $error("swap write with crossed range");

endmodule

`default_nettype wire

// ===== verif/lifo_stack_with_half_rotate_tb.sv =====
`timescale 1ns / 1ps

module lifo_stack_with_half_rotate_tb;
  import lifo_hr_pkg::*;

  localparam int STACK_DEPTH = DEFAULT_STACK_DEPTH;
  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
  localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
  // A full swap-halves pass is the slowest thing the block does.
  localparam int SWAP_WORST = 3 * STACK_DEPTH + 5;
  localparam int HOLD_CYCLES = 400;
  localparam int ITEM_BUDGET = 2000;
  localparam int CYCLE_LIMIT = 4 * (ITEM_BUDGET * (SWAP_WORST + 40) + HOLD_CYCLES);

  typedef struct packed {
    logic signed [WORD_W-1:0] pop_value;
    logic [STATUS_W-1:0]      status;
    logic [FILL_W-1:0]        fill_count;
  } stack_result_t;

  class stack_scoreboard;
    logic signed [WORD_W-1:0] entries [STACK_DEPTH];
    int unsigned              count;
    stack_result_t            pending [$];
    int unsigned              mismatches;
    int unsigned              results_seen;
    int unsigned              n_push, n_pop, n_swap, n_nop;
    int unsigned              n_dropped, n_empty, peak_count;

    function new();
      count = 0;
    endfunction

    // Apply one accepted request to the stack copy and queue its result.
    function void note_request(logic [CMD_W-1:0] cmd, logic signed [WORD_W-1:0] word);
      stack_result_t            r;
      logic signed [WORD_W-1:0] rotated [STACK_DEPTH];
      int unsigned              k;
      r.pop_value = '0;
      r.status = ST_OK;
      case (cmd)
        CMD_PUSH: begin
          n_push++;
          if (count >= STACK_DEPTH) begin
            r.status = ST_FULL;
            n_dropped++;
          end else begin
            entries[count] = word;
            count++;
          end
        end
        CMD_POP: begin
          n_pop++;
          if (count == 0) begin
            r.pop_value = EMPTY_POP_VALUE;
            r.status = ST_EMPTY;
            n_empty++;
          end else begin
            count--;
            r.pop_value = entries[count];
          end
        end
        CMD_SWAP: begin
          n_swap++;
          if (count == 0) begin
            r.status = ST_EMPTY;
            n_empty++;
          end else begin
            // The lower k = count - count/2 entries end up on top: a left rotation by k.
            k = count - count / 2;
            for (int i = 0; i < count; i++) rotated[i] = entries[(i + k) % count];
            for (int i = 0; i < count; i++) entries[i] = rotated[i];
          end
        end
        default: n_nop++;
      endcase
      if (count > peak_count) peak_count = count;
      r.fill_count = FILL_W'(count);
      pending.push_back(r);
    endfunction

    function void check_result(logic signed [WORD_W-1:0] value, logic [STATUS_W-1:0] status,
                               logic [FILL_W-1:0] fill);
      stack_result_t want;
      results_seen++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d arrived with no request outstanding: value=%0d status=%0d fill=%0d",
                   results_seen, value, status, fill);
      end else begin
        want = pending.pop_front();
        if (want.pop_value !== value || want.status !== status || want.fill_count !== fill) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: expected value=%0d status=%0d fill=%0d, got value=%0d status=%0d fill=%0d",
                     results_seen, want.pop_value, want.status, want.fill_count,
                     value, status, fill);
        end
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [CMD_W-1:0]         in_cmd = CMD_NOP;
  logic signed [WORD_W-1:0] in_push_value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [WORD_W-1:0] out_pop_value;
  logic [STATUS_W-1:0]      out_status;
  logic [FILL_W-1:0]        out_fill_count;

  stack_scoreboard board = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  int cycles = 0;

  lifo_stack_with_half_rotate #(.STACK_DEPTH(STACK_DEPTH)) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_push_value (in_push_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pop_value (out_pop_value),
    .out_status    (out_status),
    .out_fill_count(out_fill_count)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycles, board.pending.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side: check what is taken at this edge, then choose the next stall.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_result(out_pop_value, out_status, out_fill_count);
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  function automatic logic signed [WORD_W-1:0] pick_word();
    case ($urandom_range(9))
      0: return WORD_MIN;
      1: return WORD_MAX;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Offer one request and hold it until the block takes it.
  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic signed [WORD_W-1:0] word);
    int gap;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_push_value <= word;
    do @(posedge clk); while (in_stall);
    board.note_request(cmd, word);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  // Random walk of the fill level toward a target that moves every 32 requests.
  task automatic run_random(input int n);
    int target;
    int r;
    target = 0;
    for (int i = 0; i < n; i++) begin
      if (i % 32 == 0)
        target = ($urandom_range(3) == 0) ? $urandom_range(100, STACK_DEPTH + 4)
                                          : $urandom_range(0, 40);
      r = $urandom_range(99);
      if (r < 8) send_request(CMD_SWAP, $urandom);
      else if (r < 11) send_request(CMD_NOP, $urandom);
      else if ((board.count < target) == ($urandom_range(99) < 80)) send_request(CMD_PUSH, pick_word());
      else send_request(CMD_POP, $urandom);
    end
  endtask

  task automatic fill_and_drain();
    while (board.count < STACK_DEPTH) send_request(CMD_PUSH, pick_word());
    repeat (3) send_request(CMD_PUSH, pick_word());
    send_request(CMD_SWAP, $urandom);
    while (board.count > STACK_DEPTH / 2) send_request(CMD_POP, $urandom);
    send_request(CMD_SWAP, $urandom);
    while (board.count > 0) send_request(CMD_POP, $urandom);
    repeat (2) send_request(CMD_POP, $urandom);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 32;
    recv_idle_pct = 65;

    // Empty-stack behavior, a one-entry swap, then odd and small swaps.
    send_request(CMD_POP, $urandom);
    send_request(CMD_SWAP, $urandom);
    send_request(CMD_NOP, $urandom);
    send_request(CMD_PUSH, WORD_MAX);
    send_request(CMD_SWAP, $urandom);
    send_request(CMD_POP, $urandom);
    send_request(CMD_PUSH, WORD_MIN);
    send_request(CMD_PUSH, -32'sd1);
    send_request(CMD_PUSH, 32'sd0);
    send_request(CMD_PUSH, 32'sd1);
    send_request(CMD_PUSH, 32'sh5555_5555);
    send_request(CMD_SWAP, $urandom);
    send_request(CMD_NOP, $urandom);
    send_request(CMD_POP, $urandom);
    send_request(CMD_POP, $urandom);
    send_request(CMD_SWAP, $urandom);
    repeat (4) send_request(CMD_POP, $urandom);

    run_random(200);
    fill_and_drain();
    wait_for_results();

    send_idle_pct = 65;
    recv_idle_pct = 32;
    // Long receiver hold-off while requests keep coming, so the block backs up.
    hold_left <= HOLD_CYCLES;
    run_random(500);
    wait_for_results();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(500);

    wait_for_results();
    repeat (SWAP_WORST + 20) @(posedge clk);

    $display("Requests: %0d push (%0d dropped on full), %0d pop, %0d swap, %0d unused command",
             board.n_push, board.n_dropped, board.n_pop, board.n_swap, board.n_nop);
    $display("Results checked: %0d, empty-stack hits: %0d, peak fill: %0d, mismatches: %0d",
             board.results_seen, board.n_empty, board.peak_count, board.mismatches);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/lifo_hr_pkg.sv
design/lifo_stack_with_half_rotate.sv
verif/lifo_stack_with_half_rotate_tb.sv
